[rtl/keyed_record_table_defines.svh]
// assertion macros for the keyed record table
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define KRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define KRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/krt_pkg.sv]
// shared types and constants of the keyed record table
package krt_pkg;

    localparam int KEY_W           = 16;
    localparam int AMT_W           = 24;
    localparam int OP_W            = 2;
    localparam int STAT_W          = 3;
    localparam int FILL_W          = 7;
    localparam int TABLE_DEPTH_DEF = 64;

    // opcodes
    localparam logic [OP_W-1:0] OPC_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OPC_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OPC_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OPC_DUMP   = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUP     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_MISSING = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd4;

    // one stored record, as it lies in the memory word
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] ticket;
        logic [AMT_W-1:0] food;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // one result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  key;
        logic [AMT_W-1:0]  ticket;
        logic [AMT_W-1:0]  food;
        logic [FILL_W-1:0] fill;
        logic              last;
    } t_result;

endpackage

[rtl/keyed_record_table.sv]
// top level of the keyed record table: sequencer, record memory, output register
//
// Bounded table of up to TABLE_DEPTH records (16-bit key, two 24-bit amounts) in
// insertion order, held in one memory with a registered read. One request is worked
// at a time. Create, update and delete walk the stored keys at one entry per clock
// (pipelined against the memory read port). A delete that finds its key stops
// searching there and moves every later entry down a slot at one entry per clock.
// A dump alternates a read state and an output state for each stored entry, and
// holds while its result is not taken. Create on an empty table, and any request
// that fails at once on the fill count, go straight to the reply with no search.
// Results leave through a one-entry output register: the sequencer hands its reply
// over and goes back to idle while that result waits, and stalls only while the
// register is still occupied.
`include "keyed_record_table_defines.svh"

module keyed_record_table import krt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [KEY_W-1:0]  i_record_key,
    input  logic [AMT_W-1:0]  i_ticket_value,
    input  logic [AMT_W-1:0]  i_food_value,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [KEY_W-1:0]  o_out_key,
    output logic [AMT_W-1:0]  o_out_ticket,
    output logic [AMT_W-1:0]  o_out_food,
    output logic [FILL_W-1:0] o_fill_count,
    output logic              o_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic          res_valid;
    logic          res_ready;
    t_result       res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_rdata;

    logic          r_out_valid;
    t_result       r_out;

    krt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_in_valid),
        .o_req_ready    (o_in_ready),
        .i_opcode       (i_opcode),
        .i_record_key   (i_record_key),
        .i_ticket_value (i_ticket_value),
        .i_food_value   (i_food_value),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    krt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register: loads when empty or being drained this cycle
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_out_key    = r_out.key;
    assign o_out_ticket = r_out.ticket;
    assign o_out_food   = r_out.food;
    assign o_fill_count = r_out.fill;
    assign o_last       = r_out.last;

    // one request in flight: taking a request closes the request channel
    `KRT_ASSERT_NEXT(a_one_request, i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")

    // only dump entries come without the last mark, and they are always ok
    `KRT_ASSERT_NOW(a_mid_dump_ok, o_out_valid && !o_last, o_status == STAT_OK, "non-final result not ok")

    // empty-table reply is a single result with a zero count
    `KRT_ASSERT_NOW(a_empty_reply, o_out_valid && (o_status == STAT_EMPTY), o_last && (o_fill_count == '0), "bad empty reply")

    // full reply only when the count sits at the table depth
    `KRT_ASSERT_NOW(a_full_reply, o_out_valid && (o_status == STAT_FULL), o_fill_count == FILL_W'(TABLE_DEPTH), "full with room left")

endmodule

[rtl/krt_ram.sv]
// generic single-write, single-read memory with registered read data
module krt_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/krt_ctrl.sv]
// sequencer: search, update, delete shift and dump over the record memory
module krt_ctrl import krt_pkg::*; #(
    parameter int  TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [KEY_W-1:0]  i_record_key,
    input  logic [AMT_W-1:0]  i_ticket_value,
    input  logic [AMT_W-1:0]  i_food_value,
    // result side
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    // memory ports
    output logic              o_ram_we,
    output logic [AW-1:0]     o_ram_waddr,
    output t_entry            o_ram_wdata,
    output logic [AW-1:0]     o_ram_raddr,
    input  t_entry            i_ram_rdata
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEARCH   = 3'd1;
    localparam logic [2:0] ST_SHIFT    = 3'd2;
    localparam logic [2:0] ST_DUMP_RD  = 3'd3;
    localparam logic [2:0] ST_DUMP_OUT = 3'd4;
    localparam logic [2:0] ST_REPLY    = 3'd5;

    logic [2:0]        r_state,   n_state;
    logic [CNT_W-1:0]  r_count,   n_count;
    logic [CNT_W-1:0]  r_addr,    n_addr;
    logic              r_chk,     n_chk;
    logic [CNT_W-1:0]  r_chk_idx, n_chk_idx;
    logic [OP_W-1:0]   r_op,      n_op;
    logic [KEY_W-1:0]  r_key,     n_key;
    logic [AMT_W-1:0]  r_ticket,  n_ticket;
    logic [AMT_W-1:0]  r_food,    n_food;
    logic [STAT_W-1:0] r_status,  n_status;

    logic [CNT_W-1:0]  cnt_last;
    logic [CNT_W-1:0]  shift_dst;
    logic              hit;
    logic              at_end;
    logic              dump_last;

    assign cnt_last  = r_count - CNT_W'(1);
    assign shift_dst = r_chk_idx - CNT_W'(1);
    assign hit       = r_chk && (i_ram_rdata.key == r_key);
    assign at_end    = r_chk && (r_chk_idx == cnt_last);
    assign dump_last = (r_addr == cnt_last);

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_ram_raddr = r_addr[AW-1:0];

    // next-state and memory access logic
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_op        = r_op;
        n_key       = r_key;
        n_ticket    = r_ticket;
        n_food      = r_food;
        n_status    = r_status;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_chk_idx[AW-1:0];
        o_ram_wdata = '{key: r_key, ticket: r_ticket, food: r_food};
        o_res_valid = 1'b0;
        o_res       = '{status: r_status, key: r_key, ticket: '0, food: '0,
                        fill: FILL_W'(r_count), last: 1'b1};

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_op      = i_opcode;
                    n_key     = i_record_key;
                    n_ticket  = i_ticket_value;
                    n_food    = i_food_value;
                    n_addr    = '0;
                    n_chk     = 1'b0;
                    n_chk_idx = '0;
                    unique case (i_opcode) inside
                        OPC_CREATE: begin
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_status = STAT_FULL;
                                n_state  = ST_REPLY;
                            end else if (r_count == '0) begin
                                // empty table: append at once, nothing to search
                                o_ram_we    = 1'b1;
                                o_ram_waddr = '0;
                                o_ram_wdata = '{key: i_record_key, ticket: i_ticket_value,
                                                food: i_food_value};
                                n_count     = CNT_W'(1);
                                n_status    = STAT_OK;
                                n_state     = ST_REPLY;
                            end else begin
                                n_state = ST_SEARCH;
                            end
                        end
                        OPC_UPDATE, OPC_DELETE: begin
                            if (r_count == '0) begin
                                n_status = STAT_MISSING;
                                n_state  = ST_REPLY;
                            end else begin
                                n_state = ST_SEARCH;
                            end
                        end
                        OPC_DUMP: begin
                            if (r_count == '0) begin
                                n_key    = '0;
                                n_status = STAT_EMPTY;
                                n_state  = ST_REPLY;
                            end else begin
                                n_state = ST_DUMP_RD;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            // one read issued per cycle, compared once its registered read data returns
            ST_SEARCH: begin
                n_addr    = r_addr + CNT_W'(1);
                n_chk     = 1'b1;
                n_chk_idx = r_addr;
                if (hit) begin
                    unique case (r_op) inside
                        OPC_CREATE: begin
                            n_status = STAT_DUP;
                            n_state  = ST_REPLY;
                        end
                        OPC_UPDATE: begin
                            o_ram_we = 1'b1;
                            n_status = STAT_OK;
                            n_state  = ST_REPLY;
                        end
                        OPC_DELETE: begin
                            n_status = STAT_OK;
                            if (r_chk_idx == cnt_last) begin
                                // last entry removed, nothing to move
                                n_count = cnt_last;
                                n_state = ST_REPLY;
                            end else begin
                                n_addr  = r_chk_idx + CNT_W'(1);
                                n_chk   = 1'b0;
                                n_state = ST_SHIFT;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end else if (at_end) begin
                    unique case (r_op) inside
                        OPC_CREATE: begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_count[AW-1:0];
                            n_count     = r_count + CNT_W'(1);
                            n_status    = STAT_OK;
                            n_state     = ST_REPLY;
                        end
                        OPC_UPDATE, OPC_DELETE: begin
                            n_status = STAT_MISSING;
                            n_state  = ST_REPLY;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end

            // read slot i+1 while writing the previous read back one slot lower
            ST_SHIFT: begin
                n_addr    = r_addr + CNT_W'(1);
                n_chk     = 1'b1;
                n_chk_idx = r_addr;
                if (r_chk) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = shift_dst[AW-1:0];
                    o_ram_wdata = i_ram_rdata;
                    if (at_end) begin
                        n_count = cnt_last;
                        n_state = ST_REPLY;
                    end
                end
            end

            ST_DUMP_RD: begin
                n_state = ST_DUMP_OUT;
            end

            // read address held, so the read data stays put while stalled
            ST_DUMP_OUT: begin
                o_res_valid = 1'b1;
                o_res       = '{status: STAT_OK, key: i_ram_rdata.key,
                                ticket: i_ram_rdata.ticket, food: i_ram_rdata.food,
                                fill: FILL_W'(r_count), last: dump_last};
                if (i_res_ready) begin
                    if (dump_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_addr  = r_addr + CNT_W'(1);
                        n_state = ST_DUMP_RD;
                    end
                end
            end

            ST_REPLY: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_addr  <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_chk   <= n_chk;
        end
    end

    // request payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_op      <= n_op;
        r_key     <= n_key;
        r_ticket  <= n_ticket;
        r_food    <= n_food;
        r_status  <= n_status;
    end

endmodule

[tb/tb_top.sv]
// self-checking testbench for the keyed record table
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import krt_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 150;
    localparam int MAX_REPORTED    = 10;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_opcode;
    logic [KEY_W-1:0]  i_record_key;
    logic [AMT_W-1:0]  i_ticket_value;
    logic [AMT_W-1:0]  i_food_value;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [KEY_W-1:0]  o_out_key;
    logic [AMT_W-1:0]  o_out_ticket;
    logic [AMT_W-1:0]  o_out_food;
    logic [FILL_W-1:0] o_fill_count;
    logic              o_last;

    // shadow copy of the record table
    logic [KEY_W-1:0]  shadow_key    [TABLE_DEPTH_DEF];
    logic [AMT_W-1:0]  shadow_ticket [TABLE_DEPTH_DEF];
    logic [AMT_W-1:0]  shadow_food   [TABLE_DEPTH_DEF];
    int                shadow_fill;
    int                peak_fill;

    t_result pending_results[$];

    // idling controls
    bit gaps_on;
    bit stalls_on;
    bit hold_off_req;
    int hold_left;
    int stall_left;

    // bookkeeping
    int cycle_count;
    int mismatch_count;
    int requests_sent;
    int results_checked;
    int status_seen [8];

    keyed_record_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_record_key   (i_record_key),
        .i_ticket_value (i_ticket_value),
        .i_food_value   (i_food_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_key      (o_out_key),
        .o_out_ticket   (o_out_ticket),
        .o_out_food     (o_out_food),
        .o_fill_count   (o_fill_count),
        .o_last         (o_last)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // linear key search over the stored entries, -1 when absent
    function automatic int find_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // apply one request to the shadow table and queue the results it gives
    function automatic void apply_request(input logic [OP_W-1:0] op,
                                          input logic [KEY_W-1:0] key,
                                          input logic [AMT_W-1:0] tv,
                                          input logic [AMT_W-1:0] fv);
        int slot;
        logic [STAT_W-1:0] st;
        slot = find_slot(key);
        st = STAT_OK;
        case (op)
            OPC_CREATE: begin
                if (shadow_fill >= TABLE_DEPTH_DEF) begin
                    st = STAT_FULL;
                end else if (slot >= 0) begin
                    st = STAT_DUP;
                end else begin
                    shadow_key[shadow_fill]    = key;
                    shadow_ticket[shadow_fill] = tv;
                    shadow_food[shadow_fill]   = fv;
                    shadow_fill++;
                end
            end
            OPC_UPDATE: begin
                if (slot < 0) begin
                    st = STAT_MISSING;
                end else begin
                    shadow_ticket[slot] = tv;
                    shadow_food[slot]   = fv;
                end
            end
            OPC_DELETE: begin
                if (slot < 0) begin
                    st = STAT_MISSING;
                end else begin
                    for (int i = slot; i + 1 < shadow_fill; i++) begin
                        shadow_key[i]    = shadow_key[i+1];
                        shadow_ticket[i] = shadow_ticket[i+1];
                        shadow_food[i]   = shadow_food[i+1];
                    end
                    shadow_fill--;
                end
            end
            default: begin
                // dump walks every stored entry, or reports an empty table
                if (shadow_fill == 0) begin
                    pending_results.push_back('{status: STAT_EMPTY, key: '0,
                        ticket: '0, food: '0, fill: '0, last: 1'b1});
                end else begin
                    for (int i = 0; i < shadow_fill; i++) begin
                        pending_results.push_back('{status: STAT_OK,
                            key: shadow_key[i], ticket: shadow_ticket[i],
                            food: shadow_food[i], fill: FILL_W'(shadow_fill),
                            last: (i + 1 == shadow_fill)});
                    end
                end
                return;
            end
        endcase
        if (shadow_fill > peak_fill) begin
            peak_fill = shadow_fill;
        end
        pending_results.push_back('{status: st, key: key, ticket: '0, food: '0,
            fill: FILL_W'(shadow_fill), last: 1'b1});
    endfunction

    // offer one request, with an optional idle burst first
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [KEY_W-1:0] key,
                                input logic [AMT_W-1:0] tv,
                                input logic [AMT_W-1:0] fv);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_record_key   <= key;
        i_ticket_value <= tv;
        i_food_value   <= fv;
        do @(posedge i_clk); while (!o_in_ready);
        apply_request(op, key, tv, fv);
        requests_sent++;
    endtask

    // stored key with the given chance in percent, else a random key
    function automatic logic [KEY_W-1:0] pick_key(input int hit_pct);
        if (shadow_fill != 0 && $urandom_range(0, 99) < hit_pct) begin
            return shadow_key[$urandom_range(0, shadow_fill - 1)];
        end
        return KEY_W'($urandom);
    endfunction

    // extremes of every field and the special cases short of a full table, on a small table
    task automatic test_directed();
        send_request(OPC_DUMP,   16'h0000, '0, '0);
        send_request(OPC_UPDATE, 16'h1234, 24'hABCDEF, 24'h123456);
        send_request(OPC_DELETE, 16'hFFFF, '0, '0);
        send_request(OPC_CREATE, 16'h0000, 24'h000000, 24'h000000);
        send_request(OPC_CREATE, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_request(OPC_CREATE, 16'hAAAA, 24'h555555, 24'hAAAAAA);
        send_request(OPC_CREATE, 16'h5555, 24'hAAAAAA, 24'h555555);
        send_request(OPC_CREATE, 16'hFFFF, 24'h000001, 24'h000002);
        send_request(OPC_CREATE, 16'h0000, 24'h000003, 24'h000004);
        send_request(OPC_UPDATE, 16'h0000, 24'hFFFFFF, 24'hFFFFFF);
        send_request(OPC_UPDATE, 16'h5555, 24'h000000, 24'h000000);
        send_request(OPC_UPDATE, 16'h0001, 24'h000001, 24'h000001);
        send_request(OPC_DUMP,   16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_request(OPC_DELETE, 16'h0000, '0, '0);
        send_request(OPC_DUMP,   16'h0000, '0, '0);
        send_request(OPC_DELETE, 16'h5555, '0, '0);
        send_request(OPC_DELETE, 16'h5555, '0, '0);
        send_request(OPC_DELETE, 16'hAAAA, '0, '0);
        send_request(OPC_DUMP,   16'h0000, '0, '0);
        send_request(OPC_DELETE, 16'hFFFF, '0, '0);
        send_request(OPC_DUMP,   16'h1111, 24'h222222, 24'h333333);
    endtask

    // fill the table to capacity, then hit the full case and edge deletes
    task automatic test_capacity();
        logic [KEY_W-1:0] key;
        while (shadow_fill < TABLE_DEPTH_DEF) begin
            send_request(OPC_CREATE, KEY_W'($urandom), AMT_W'($urandom),
                         AMT_W'($urandom));
        end
        // full check wins over the duplicate check
        send_request(OPC_CREATE, shadow_key[0], AMT_W'($urandom), AMT_W'($urandom));
        send_request(OPC_CREATE, KEY_W'($urandom), AMT_W'($urandom), AMT_W'($urandom));
        send_request(OPC_UPDATE, shadow_key[TABLE_DEPTH_DEF-1], AMT_W'($urandom),
                     AMT_W'($urandom));
        send_request(OPC_DUMP, '0, '0, '0);
        key = shadow_key[TABLE_DEPTH_DEF-1];
        send_request(OPC_DELETE, key, '0, '0);
        key = shadow_key[0];
        send_request(OPC_DELETE, key, '0, '0);
        key = shadow_key[shadow_fill / 2];
        send_request(OPC_DELETE, key, '0, '0);
        send_request(OPC_DUMP, '0, '0, '0);
    endtask

    // long result stall while requests keep coming, so the block backs up
    task automatic test_back_pressure();
        hold_off_req = 1'b1;
        send_request(OPC_DUMP, '0, '0, '0);
        for (int i = 0; i < 8; i++) begin
            send_request((i % 2 == 0) ? OPC_UPDATE : OPC_DUMP, pick_key(80),
                         AMT_W'($urandom), AMT_W'($urandom));
        end
    endtask

    // random mix of requests; updates and deletes mostly aim at stored keys
    task automatic test_random_mix(input int count, input int create_pct,
                                   input int delete_pct);
        int pick;
        logic [OP_W-1:0] op;
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < create_pct) begin
                op  = OPC_CREATE;
                key = pick_key(15);
            end else if (pick < create_pct + 15) begin
                op  = OPC_UPDATE;
                key = pick_key(80);
            end else if (pick < create_pct + 15 + delete_pct) begin
                op  = OPC_DELETE;
                key = pick_key(80);
            end else begin
                op  = OPC_DUMP;
                key = KEY_W'($urandom);
            end
            send_request(op, key, AMT_W'($urandom), AMT_W'($urandom));
        end
    endtask

    // result side: random stall bursts and the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{status: o_status, key: o_out_key, ticket: o_out_ticket,
                    food: o_out_food, fill: o_fill_count, last: o_last};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED) begin
                    $display("unexpected result: st=%0d key=%h t=%h f=%h fill=%0d last=%b",
                             got.status, got.key, got.ticket, got.food, got.fill,
                             got.last);
                end
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED) begin
                        $display("result %0d expected st=%0d key=%h t=%h f=%h fill=%0d last=%b",
                                 results_checked, want.status, want.key, want.ticket,
                                 want.food, want.fill, want.last);
                        $display("result %0d actual   st=%0d key=%h t=%h f=%h fill=%0d last=%b",
                                 results_checked, got.status, got.key, got.ticket,
                                 got.food, got.fill, got.last);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("keyed_record_table: mismatch");
            $finish;
        end
    end

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OPC_CREATE;
        i_record_key   = '0;
        i_ticket_value = '0;
        i_food_value   = '0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_capacity();
        test_back_pressure();
        test_random_mix(40, 50, 20);
        test_random_mix(40, 20, 50);
        test_random_mix(24, 50, 20);

        // last stretch runs at full rate on both sides
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random_mix(24, 35, 35);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            mismatch_count++;
        end
        $display("covered %0d requests and %0d results, peak fill %0d of %0d",
                 requests_sent, results_checked, peak_fill, TABLE_DEPTH_DEF);
        $display("status mix: ok %0d, full %0d, duplicate %0d, not found %0d, empty %0d",
                 status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_DUP],
                 status_seen[STAT_MISSING], status_seen[STAT_EMPTY]);
        if (mismatch_count == 0) begin
            $display("keyed_record_table: match");
        end else begin
            $display("keyed_record_table: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/krt_pkg.sv
rtl/krt_ram.sv
rtl/krt_ctrl.sv
rtl/keyed_record_table.sv
tb/tb_top.sv
